[rtl/biopotential_frame_deframer_autorange_macros.svh]
// Assertion macros for the biopotential frame deframer
`ifndef BIOPOTENTIAL_FRAME_DEFRAMER_AUTORANGE_MACROS_SVH
`define BIOPOTENTIAL_FRAME_DEFRAMER_AUTORANGE_MACROS_SVH
`ifndef SYNTHESIS
`define BFDA_ASSERT_IMP(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("bfda assertion failed");
`define BFDA_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("bfda assertion failed");
`else
`define BFDA_ASSERT_IMP(label, cond, prop)
`define BFDA_ASSERT_NEXT(label, cond, prop)
`endif
`endif

[rtl/bfda_pkg.sv]
// Types and constants shared by the frame deframer modules
`default_nettype none
package bfda_pkg;

    localparam logic [3:0] FRAME_BYTES   = 4'd9;
    localparam logic [3:0] POS_FIRST_CH  = 4'd3;
    localparam logic [3:0] POS_SECOND_CH = 4'd6;
    localparam logic [3:0] POS_LAST      = 4'd8;

    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_CALIB_CHANNEL = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CALIB_FRAMES  = 8'd1;

    localparam logic        CALIB_CHANNEL_RESET = 1'b1;
    localparam logic [15:0] CALIB_FRAMES_RESET  = 16'd500;

    localparam logic signed [23:0] SAMPLE_MIN = 24'sh800000;
    localparam logic signed [23:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic [3:0]         HEADER_CODE = 4'b1100;

    // 180 and 220 in Q.24
    localparam logic [32:0]        GAIN_NUM_Q = 33'd3019898880;
    localparam logic signed [63:0] OFFSET_Q   = 64'sd3690987520;
    localparam logic [5:0]         DIV_STEPS  = 6'd33;

    typedef struct packed {
        logic [7:0] spi_byte;
        logic       frame_start;
    } in_item_t;

    typedef struct packed {
        logic signed [23:0] first_sample;
        logic signed [23:0] second_sample;
        logic [4:0]         lead_off_bits;
        logic [1:0]         gpio_level;
        logic               header_ok;
        logic               calib_done;
        logic               calib_error;
        logic [31:0]        gain_q;
        logic signed [63:0] offset_q;
    } out_item_t;

    // One decoded frame as handed from front to back
    typedef struct packed {
        logic signed [23:0] first_sample;
        logic signed [23:0] second_sample;
        logic [4:0]         lead_off_bits;
        logic [1:0]         gpio_level;
        logic               header_ok;
        logic               calib_done;
        logic signed [23:0] run_max;
        logic signed [23:0] run_min;
    } frame_rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_MUL,
        B_FIN
    } back_state_t;

endpackage
`default_nettype wire

[rtl/biopotential_frame_deframer_autorange.sv]
// Top level of the biopotential frame deframer with min/max auto-ranging.
// An ordinary frame is registered into the frame queue and then into the output register.
// The frame that ends calibration also passes a 33-step restoring divider for the gain,
// a multiply state and a subtract state; on a flat range the divider is skipped.
// Throughput: one byte per cycle; bytes stall while the frame queue is full.
// Reset (rst_n, async, low) clears frame position, calibration, registers and queue.
`default_nettype none
`include "biopotential_frame_deframer_autorange_macros.svh"
module biopotential_frame_deframer_autorange #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire bfda_pkg::in_item_t                    in_data,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output bfda_pkg::out_item_t                        out_data,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [bfda_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [bfda_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import bfda_pkg::*;

    logic        calib_channel_reg;
    logic [15:0] calib_frames_reg;

    logic        accept;
    logic        push, pop;
    frame_rec_t  wr_rec, rd_rec;
    queue_stat_t q_stat;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_stat.full;
    assign accept    = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calib_channel_reg <= CALIB_CHANNEL_RESET;
            calib_frames_reg  <= CALIB_FRAMES_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_CALIB_CHANNEL)
            begin
                calib_channel_reg <= cfg_data[0];
            end
            else if (cfg_index == REG_CALIB_FRAMES)
            begin
                calib_frames_reg <= cfg_data[15:0];
            end
        end
    end

    bfda_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .in_data       (in_data),
        .calib_channel (calib_channel_reg),
        .calib_frames  (calib_frames_reg),
        .push          (push),
        .rec           (wr_rec)
    );

    bfda_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_rec (wr_rec),
        .pop    (pop),
        .rd_rec (rd_rec),
        .stat   (q_stat)
    );

    bfda_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_rec    (rd_rec),
        .q_stat    (q_stat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    `BFDA_ASSERT_IMP(a_no_overflow, push, !q_stat.full)
    `BFDA_ASSERT_NEXT(a_push_lands, push, !q_stat.empty)
    `BFDA_ASSERT_IMP(a_err_zero_gain, out_valid && out_data.calib_error, out_data.calib_done && (out_data.gain_q == 32'd0))
    `BFDA_ASSERT_IMP(a_plain_zero, out_valid && !out_data.calib_done, (out_data.gain_q == 32'd0) && (out_data.offset_q == 64'sd0))

endmodule
`default_nettype wire

[rtl/bfda_front.sv]
// Front end: byte assembly into frames and min/max range tracking
`default_nettype none
module bfda_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire bfda_pkg::in_item_t  in_data,
    input  wire logic                calib_channel,
    input  wire logic [15:0]         calib_frames,
    output logic                     push,
    output bfda_pkg::frame_rec_t     rec
);
    import bfda_pkg::*;

    logic [3:0]         byte_pos_reg, byte_pos_next;
    logic [23:0]        status_reg, status_next;
    logic [23:0]        first_raw_reg, first_raw_next;
    logic [15:0]        second_part_reg, second_part_next;
    logic [16:0]        frames_seen_reg, frames_seen_next;
    logic signed [23:0] run_max_reg, run_max_next;
    logic signed [23:0] run_min_reg, run_min_next;
    logic               calibrated_reg, calibrated_next;

    logic [3:0]         pos;
    logic               active;
    logic signed [23:0] s1, s2, x, new_max, new_min;
    logic [16:0]        fs_inc, limit;
    logic               track, done;

    always_comb
    begin
        pos     = in_data.frame_start ? 4'd0 : byte_pos_reg;
        active  = accept && (pos < FRAME_BYTES);
        s1      = first_raw_reg;
        s2      = {second_part_reg, in_data.spi_byte};
        x       = calib_channel ? s2 : s1;
        new_max = (x > run_max_reg) ? x : run_max_reg;
        new_min = (x < run_min_reg) ? x : run_min_reg;
        fs_inc  = (frames_seen_reg == 17'h1FFFF) ? frames_seen_reg : frames_seen_reg + 17'd1;
        limit   = (calib_frames == 16'd0) ? 17'd1 : {1'b0, calib_frames};
        track   = !calibrated_reg && (frames_seen_reg != 17'd0);
        done    = track && ((fs_inc - 17'd1) >= limit);
        push    = active && (pos == POS_LAST);
    end

    always_comb
    begin
        byte_pos_next    = byte_pos_reg;
        status_next      = status_reg;
        first_raw_next   = first_raw_reg;
        second_part_next = second_part_reg;
        frames_seen_next = frames_seen_reg;
        run_max_next     = run_max_reg;
        run_min_next     = run_min_reg;
        calibrated_next  = calibrated_reg;
        if (accept)
        begin
            byte_pos_next = pos;
        end
        if (active)
        begin
            byte_pos_next = pos + 4'd1;
            if (pos < POS_FIRST_CH)
            begin
                status_next = {status_reg[15:0], in_data.spi_byte};
            end
            else if (pos < POS_SECOND_CH)
            begin
                first_raw_next = {first_raw_reg[15:0], in_data.spi_byte};
            end
            else if (pos < POS_LAST)
            begin
                second_part_next = {second_part_reg[7:0], in_data.spi_byte};
            end
            else if (!calibrated_reg)
            begin
                // skip the first frame, then track the chosen channel
                if (frames_seen_reg == 17'd0)
                begin
                    frames_seen_next = 17'd1;
                end
                else
                begin
                    run_max_next     = new_max;
                    run_min_next     = new_min;
                    frames_seen_next = fs_inc;
                    calibrated_next  = done;
                end
            end
        end
    end

    always_comb
    begin
        rec.first_sample  = s1;
        rec.second_sample = s2;
        rec.lead_off_bits = status_reg[19:15];
        rec.gpio_level    = status_reg[14:13];
        rec.header_ok     = (status_reg[23:20] == HEADER_CODE);
        rec.calib_done    = done;
        rec.run_max       = new_max;
        rec.run_min       = new_min;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg    <= 4'd0;
            status_reg      <= 24'd0;
            first_raw_reg   <= 24'd0;
            second_part_reg <= 16'd0;
            frames_seen_reg <= 17'd0;
            run_max_reg     <= SAMPLE_MIN;
            run_min_reg     <= SAMPLE_MAX;
            calibrated_reg  <= 1'b0;
        end
        else
        begin
            byte_pos_reg    <= byte_pos_next;
            status_reg      <= status_next;
            first_raw_reg   <= first_raw_next;
            second_part_reg <= second_part_next;
            frames_seen_reg <= frames_seen_next;
            run_max_reg     <= run_max_next;
            run_min_reg     <= run_min_next;
            calibrated_reg  <= calibrated_next;
        end
    end

endmodule
`default_nettype wire

[rtl/bfda_queue.sv]
// Small frame queue between front and back
`default_nettype none
module bfda_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire bfda_pkg::frame_rec_t wr_rec,
    input  wire logic                 pop,
    output bfda_pkg::frame_rec_t      rd_rec,
    output bfda_pkg::queue_stat_t     stat
);
    import bfda_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    frame_rec_t       mem [DEPTH];
    frame_rec_t       rd_rec_reg;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        stat.full   = (count_reg == FULL_CNT);
        stat.empty  = (count_reg == '0);
        rd_rec      = rd_rec_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_rec;
        end
        // pass the incoming record straight through when it lands in the read slot
        if (push && (wr_ptr_reg == rd_ptr_next))
        begin
            rd_rec_reg <= wr_rec;
        end
        else
        begin
            rd_rec_reg <= mem[rd_ptr_next];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

[rtl/bfda_back.sv]
// Back end: gain division, offset product and output register
`default_nettype none
module bfda_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire bfda_pkg::frame_rec_t  rd_rec,
    input  wire bfda_pkg::queue_stat_t q_stat,
    output logic                       pop,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output bfda_pkg::out_item_t        out_data
);
    import bfda_pkg::*;

    back_state_t        state_reg, state_next;
    frame_rec_t         hold_reg;
    logic               err_reg;
    logic [23:0]        diff_reg;
    logic [23:0]        rem_reg;
    logic [32:0]        quo_reg;
    logic [5:0]         cnt_reg;
    logic [31:0]        gain_reg;
    logic signed [56:0] prod_reg;
    out_item_t          out_reg;
    logic               out_valid_reg;

    logic               out_free;
    logic               take_plain, take_calib, step_div, load_fin;
    logic               rec_err;
    logic [24:0]        rec_diff;
    logic [24:0]        shifted;
    logic               q_bit;
    logic [32:0]        quo_step;
    logic [23:0]        rem_step;

    always_comb
    begin
        out_free = !out_valid_reg || !out_stall;
        rec_err  = (rd_rec.run_max <= rd_rec.run_min);
        rec_diff = 25'({rd_rec.run_max[23], rd_rec.run_max} - {rd_rec.run_min[23], rd_rec.run_min});
        shifted  = {rem_reg, quo_reg[32]};
        q_bit    = (shifted >= {1'b0, diff_reg});
        rem_step = q_bit ? 24'(shifted - {1'b0, diff_reg}) : shifted[23:0];
        quo_step = {quo_reg[31:0], q_bit};
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_stat.empty && out_free && rd_rec.calib_done)
                begin
                    state_next = rec_err ? B_MUL : B_DIV;
                end
            end
            B_DIV:
            begin
                if (cnt_reg == 6'd1)
                begin
                    state_next = B_MUL;
                end
            end
            B_MUL:
            begin
                state_next = B_FIN;
            end
            B_FIN:
            begin
                if (out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        take_plain = 1'b0;
        take_calib = 1'b0;
        step_div   = 1'b0;
        load_fin   = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_stat.empty && out_free)
                begin
                    take_plain = !rd_rec.calib_done;
                    take_calib = rd_rec.calib_done;
                end
            end
            B_DIV:
            begin
                step_div = 1'b1;
            end
            B_MUL:
            begin
            end
            B_FIN:
            begin
                load_fin = out_free;
            end
            default:
            begin
            end
        endcase
        pop = take_plain || take_calib;
    end

    always_ff @(posedge clk)
    begin
        if (take_calib)
        begin
            hold_reg <= rd_rec;
            err_reg  <= rec_err;
            diff_reg <= rec_diff[23:0];
            rem_reg  <= 24'd0;
            // rounding: add half the divisor before dividing
            quo_reg  <= GAIN_NUM_Q + {9'd0, rec_diff[24:1]};
            cnt_reg  <= DIV_STEPS;
            gain_reg <= 32'd0;
        end
        if (step_div)
        begin
            rem_reg <= rem_step;
            quo_reg <= quo_step;
            cnt_reg <= cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                gain_reg <= quo_step[31:0];
            end
        end
        if (state_reg == B_MUL)
        begin
            prod_reg <= $signed({1'b0, gain_reg}) * hold_reg.run_max;
        end
        if (take_plain)
        begin
            out_reg.first_sample  <= rd_rec.first_sample;
            out_reg.second_sample <= rd_rec.second_sample;
            out_reg.lead_off_bits <= rd_rec.lead_off_bits;
            out_reg.gpio_level    <= rd_rec.gpio_level;
            out_reg.header_ok     <= rd_rec.header_ok;
            out_reg.calib_done    <= 1'b0;
            out_reg.calib_error   <= 1'b0;
            out_reg.gain_q        <= 32'd0;
            out_reg.offset_q      <= 64'sd0;
        end
        else if (load_fin)
        begin
            out_reg.first_sample  <= hold_reg.first_sample;
            out_reg.second_sample <= hold_reg.second_sample;
            out_reg.lead_off_bits <= hold_reg.lead_off_bits;
            out_reg.gpio_level    <= hold_reg.gpio_level;
            out_reg.header_ok     <= hold_reg.header_ok;
            out_reg.calib_done    <= 1'b1;
            out_reg.calib_error   <= err_reg;
            out_reg.gain_q        <= gain_reg;
            out_reg.offset_q      <= OFFSET_Q - 64'(prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (take_plain || load_fin)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
`default_nettype wire

[test/frame_result_checker.sv]
// Frame result checker: predicts deframed frames and calibration, compares them on the output
module frame_result_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_stall,
    input  bfda_pkg::in_item_t                   in_data,
    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  bfda_pkg::out_item_t                  out_data,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [bfda_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bfda_pkg::CFG_DATA_W-1:0]      cfg_data,
    output int unsigned                          mismatches,
    output int unsigned                          pending,
    output int unsigned                          frames_checked,
    output int unsigned                          range_locks,
    output int unsigned                          flat_ranges
);
    timeunit 1ns;
    timeprecision 1ps;
    import bfda_pkg::*;

    localparam longint Q24_ONE      = 64'sd16777216;
    localparam longint GAIN_SPAN    = 180;
    localparam longint OFFSET_LEVEL = 220;
    localparam int     LAST_BYTE    = 9;
    localparam int unsigned TRACK_CAP = 'h1FFFF;

    // predictor state
    int                 frame_pos = 0;
    logic [23:0]        status_bits = '0;
    logic [23:0]        ch1_raw = '0;
    logic [15:0]        ch2_hi = '0;
    int unsigned        tracked = 0;
    logic signed [23:0] peak_hi = SAMPLE_MIN;
    logic signed [23:0] peak_lo = SAMPLE_MAX;
    bit                 range_locked = 1'b0;
    logic               sel_channel = CALIB_CHANNEL_RESET;
    logic [15:0]        target_frames = CALIB_FRAMES_RESET;

    out_item_t expected_frames[$];
    out_item_t want;

    int unsigned n_mismatch = 0;
    int unsigned n_pending = 0;
    int unsigned n_checked = 0;
    int unsigned n_locks = 0;
    int unsigned n_flat = 0;

    assign mismatches     = n_mismatch;
    assign pending        = n_pending;
    assign frames_checked = n_checked;
    assign range_locks    = n_locks;
    assign flat_ranges    = n_flat;

    task automatic report_mismatch(input string msg);
        n_mismatch++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_val,
                               input logic [63:0] got_val);
        if (exp_val !== got_val)
            report_mismatch($sformatf("frame %0d %s: expected %0h, got %0h",
                                      n_checked, name, exp_val, got_val));
    endtask

    // Advance the frame assembler by one byte; queue a result on the last byte.
    task automatic predict_byte(input in_item_t it);
        logic signed [23:0] s1;
        logic signed [23:0] s2;
        logic signed [23:0] pick;
        logic [31:0]        gain;
        longint             span;
        longint             quot;
        int unsigned        need;
        out_item_t          res;
        if (it.frame_start)
            frame_pos = 0;
        if (frame_pos >= LAST_BYTE)
            return;
        frame_pos++;
        if (frame_pos <= 3) begin
            status_bits = {status_bits[15:0], it.spi_byte};
            return;
        end
        if (frame_pos <= 6) begin
            ch1_raw = {ch1_raw[15:0], it.spi_byte};
            return;
        end
        if (frame_pos < LAST_BYTE) begin
            ch2_hi = {ch2_hi[7:0], it.spi_byte};
            return;
        end
        s1 = ch1_raw;
        s2 = {ch2_hi, it.spi_byte};
        res = '0;
        if (!range_locked) begin
            if (tracked == 0) begin
                // first frame after reset is dropped from the range
                tracked = 1;
            end
            else begin
                need = (target_frames == 0) ? 1 : target_frames;
                pick = sel_channel ? s2 : s1;
                if (pick > peak_hi)
                    peak_hi = pick;
                if (pick < peak_lo)
                    peak_lo = pick;
                if (tracked < TRACK_CAP)
                    tracked++;
                if (tracked - 1 >= need) begin
                    range_locked = 1'b1;
                    n_locks++;
                    res.calib_done = 1'b1;
                    if (peak_hi <= peak_lo) begin
                        res.calib_error = 1'b1;
                        gain = '0;
                        n_flat++;
                    end
                    else begin
                        span = longint'(peak_hi) - longint'(peak_lo);
                        quot = (GAIN_SPAN * Q24_ONE + span / 2) / span;
                        gain = quot[31:0];
                    end
                    res.gain_q = gain;
                    res.offset_q = OFFSET_LEVEL * Q24_ONE
                                   - longint'({32'd0, gain}) * longint'(peak_hi);
                end
            end
        end
        res.first_sample  = s1;
        res.second_sample = s2;
        res.lead_off_bits = status_bits[19:15];
        res.gpio_level    = status_bits[14:13];
        res.header_ok     = (status_bits[23:20] == HEADER_CODE);
        expected_frames.push_back(res);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            frame_pos     = 0;
            status_bits   = '0;
            ch1_raw       = '0;
            ch2_hi        = '0;
            tracked       = 0;
            peak_hi       = SAMPLE_MIN;
            peak_lo       = SAMPLE_MAX;
            range_locked  = 1'b0;
            sel_channel   = CALIB_CHANNEL_RESET;
            target_frames = CALIB_FRAMES_RESET;
            expected_frames.delete();
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_CALIB_CHANNEL)
                    sel_channel = cfg_data[0];
                else if (cfg_index == REG_CALIB_FRAMES)
                    target_frames = cfg_data;
            end
            if (in_valid && !in_stall)
                predict_byte(in_data);
            if (out_valid && !out_stall) begin
                if (expected_frames.size() == 0) begin
                    report_mismatch("result transaction with no frame outstanding");
                end
                else begin
                    want = expected_frames.pop_front();
                    n_checked++;
                    check_field("first_sample", want.first_sample, out_data.first_sample);
                    check_field("second_sample", want.second_sample,
                                out_data.second_sample);
                    check_field("lead_off_bits", want.lead_off_bits,
                                out_data.lead_off_bits);
                    check_field("gpio_level", want.gpio_level, out_data.gpio_level);
                    check_field("header_ok", want.header_ok, out_data.header_ok);
                    check_field("calib_done", want.calib_done, out_data.calib_done);
                    check_field("calib_error", want.calib_error, out_data.calib_error);
                    check_field("gain_q", want.gain_q, out_data.gain_q);
                    check_field("offset_q", want.offset_q, out_data.offset_q);
                end
            end
        end
        n_pending = expected_frames.size();
    end

endmodule

[test/testbench.sv]
// Testbench top: drives byte streams and register writes into the deframer and gives the verdict
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import bfda_pkg::*;

    localparam int unsigned IDLE_LIMIT   = 5000;
    localparam int unsigned LONG_HOLD    = 400;
    localparam int unsigned HOLD_AT      = 20;
    localparam int unsigned SETTLE_PAD   = 50;
    localparam logic [23:0] FLAT_LEVEL   = 24'h7FFFFF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   in_valid = 1'b0;
    logic                   in_stall;
    in_item_t               in_data = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b1;
    out_item_t              out_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int unsigned mismatches;
    int unsigned pending;
    int unsigned frames_checked;
    int unsigned range_locks;
    int unsigned flat_ranges;

    int unsigned n_bytes = 0;
    int unsigned idle_cycles = 0;
    bit          tx_burst = 1'b0;
    int unsigned flat_left = 0;
    logic        flat_channel = 1'b0;

    always #5 clk = ~clk;

    biopotential_frame_deframer_autorange i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    frame_result_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .pending        (pending),
        .frames_checked (frames_checked),
        .range_locks    (range_locks),
        .flat_ranges    (flat_ranges)
    );

    // end the run if no channel moves a transaction for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end
        else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic start);
        int unsigned gap;
        gap = tx_burst ? 0 : $urandom_range(0, 12);
        @(negedge clk);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{spi_byte: value, frame_start: start};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        n_bytes++;
    endtask

    // send the first len bytes of a frame; only byte 0 may carry frame_start
    task automatic send_frame(input logic [23:0] status, input logic [23:0] ch1,
                              input logic [23:0] ch2, input logic start, input int len);
        logic [71:0] bits;
        bits = {status, ch1, ch2};
        for (int k = 0; k < len; k++)
            send_byte(bits[71 - 8 * k -: 8], (k == 0) ? start : 1'b0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // hold the input until every frame has come out, then give the back end time to drain
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_PAD) @(negedge clk);
    endtask

    function automatic logic [23:0] draw_sample();
        case ($urandom_range(0, 6))
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return 24'hFFFFFF;
            3: return 24'($urandom_range(0, 7));
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic random_frame();
        logic [23:0] status;
        logic [23:0] ch1;
        logic [23:0] ch2;
        int unsigned kind;
        status = {($urandom_range(0, 6) != 0) ? HEADER_CODE : 4'($urandom), 20'($urandom)};
        ch1 = draw_sample();
        ch2 = draw_sample();
        if (flat_left != 0) begin
            if (flat_channel)
                ch2 = FLAT_LEVEL;
            else
                ch1 = FLAT_LEVEL;
        end
        tx_burst = ($urandom_range(0, 4) == 0);
        kind = $urandom_range(0, 99);
        if (kind >= 94) begin
            // no frame start after a finished frame: the block drops these bytes
            send_frame(status, ch1, ch2, 1'b0, 9);
            return;
        end
        if (kind >= 80 && kind < 88)
            send_frame(24'($urandom), 24'($urandom), 24'($urandom), 1'b1,
                       $urandom_range(1, 8));
        send_frame(status, ch1, ch2, 1'b1, 9);
        if (flat_left != 0)
            flat_left--;
        if (kind >= 88)
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
    endtask

    // result side: random stall per transaction, one long hold-off to back up the block
    initial
    begin
        int unsigned got;
        int unsigned gap;
        bit          rx_burst;
        got = 0;
        rx_burst = 1'b0;
        @(posedge rst_n);
        forever begin
            if (got % 16 == 0)
                rx_burst = ($urandom_range(0, 3) == 0);
            gap = rx_burst ? 0 : $urandom_range(0, 12);
            if (got == HOLD_AT)
                gap = LONG_HOLD;
            @(negedge clk);
            if (gap != 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            got++;
        end
    end

    initial
    begin
        logic [CFG_DATA_W-1:0] chan_word;
        bit                    flat_mode;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_reg(REG_CALIB_FRAMES, 16'hFFFF);
        write_reg(REG_CALIB_CHANNEL, {15'($urandom), 1'b0});

        // right after reset the first byte counts as byte 0 without a frame start
        send_frame(24'hCFFFFF, 24'h800000, 24'h7FFFFF, 1'b0, 9);
        // abandoned frame, restarted by the next frame start
        send_frame(24'hC00000, 24'h123456, 24'h654321, 1'b1, 5);
        // bad header, still tracked
        send_frame(24'h300000, 24'h7FFFFF, 24'h800000, 1'b1, 9);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);

        // either a flat range (gain forced to zero) or a real span
        settle();
        flat_mode = ($urandom_range(0, 2) == 0);
        chan_word = 16'($urandom);
        flat_channel = chan_word[0];
        write_reg(REG_CALIB_CHANNEL, chan_word);
        if (flat_mode) begin
            write_reg(REG_CALIB_FRAMES, 16'($urandom_range(0, 1)));
            flat_left = 4;
        end
        else begin
            write_reg(REG_CALIB_FRAMES, 16'($urandom_range(2, 12)));
        end
        while (n_bytes < 250) random_frame();

        settle();
        write_reg(CFG_INDEX_W'($urandom_range(2, 255)), 16'($urandom));
        write_reg(REG_CALIB_CHANNEL, 16'($urandom));
        write_reg(REG_CALIB_FRAMES, 16'($urandom));
        while (n_bytes < 520) random_frame();

        settle();
        $display("run: %0d bytes sent, %0d frames checked", n_bytes, frames_checked);
        $display("calibration locked %0d time(s), %0d with a flat range",
                 range_locks, flat_ranges);
        if (mismatches == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
